>>> hw/rtl/srq_pkg.sv
// Shared types and constants for the sequence reorder queue.
// No dependencies; imported by srq_ram users and the top level.
`default_nettype none
package srq_pkg;

  localparam int WIN_DEPTH = 16;
  localparam int WIN_AW    = $clog2(WIN_DEPTH);
  localparam int NUM_W     = 31;
  localparam int DATA_W    = 32;

  typedef enum logic [1:0] {
    ACT_PUSH = 2'd0,
    ACT_POP  = 2'd1,
    ACT_PEEK = 2'd2,
    ACT_NOP  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_STALE     = 2'd1,
    ST_BEYOND    = 2'd2,
    ST_NOT_READY = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]        action;
    logic [NUM_W-1:0]  seq_num;
    logic [DATA_W-1:0] payload;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic              data_valid;
    logic [DATA_W-1:0] payload_out;
    logic [NUM_W-1:0]  head_out;
  } out_item_t;

endpackage
`default_nettype wire

>>> hw/rtl/srq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module srq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> hw/rtl/sequence_reorder_queue_unit.sv
// Sequence reorder queue top level: command port, config register, slot control.
// Depends on srq_pkg and srq_ram.
//
// Usage:
//   A transaction enters on in_item when start is high and busy is low.
//   action push stores payload at slot seq_num - head if in the window; pop and peek
//   return the head entry once it has been filled; pop advances the head.
//   Each transaction yields exactly one result on out_item, marked by
//   out_strobe for one cycle. The receiver cannot stall; results are never held.
//   out_strobe and out_item are registered: the accepted item is held in item_r
//   during the S_EXEC state and the result is registered from there.
//   A new transaction is not taken until the last one is through: busy is high
//   in the S_EXEC state after acceptance, while the head slot read from the payload
//   RAM returns and the slot is updated (one RAM port read, one write).
//   cfg_we writes start_number from cfg_wdata at any edge outside reset; the head
//   takes this number on the first push after reset.
//   Reset (rst_n low, synchronous) clears all slot valid bits, the head, the
//   started flag and start_number. Payload RAM contents are not cleared; an
//   entry is only returned when its valid bit is set.
`default_nettype none
module sequence_reorder_queue_unit
  import srq_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire in_item_t         in_item,
  output logic                  out_strobe,
  output out_item_t             out_item,
  input  wire logic             cfg_we,
  input  wire logic [NUM_W-1:0] cfg_wdata
);

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t                state_r, state_nxt;
  in_item_t              item_r;
  logic [NUM_W-1:0]      start_num_r;
  logic [NUM_W-1:0]      head_num_r, head_num_nxt;
  logic [WIN_AW-1:0]     head_slot_r, head_slot_nxt;
  logic                  started_r, started_nxt;
  logic [WIN_DEPTH-1:0]  valid_r, valid_nxt;
  logic                  out_strobe_r, out_strobe_nxt;
  out_item_t             out_item_r, out_item_nxt;

  logic                  ram_we;
  logic [WIN_AW-1:0]     ram_waddr;
  logic [DATA_W-1:0]     ram_rdata;

  logic [NUM_W-1:0]      eff_head;
  logic [NUM_W-1:0]      diff;
  logic                  accept;

  assign accept = start && !busy;
  assign busy   = (state_r == S_EXEC);

  srq_ram #(
    .WIDTH(DATA_W),
    .DEPTH(WIN_DEPTH)
  ) u_slot_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(item_r.payload),
    .raddr(head_slot_r),
    .rdata(ram_rdata)
  );

  assign eff_head  = started_r ? head_num_r : start_num_r;
  assign diff      = item_r.seq_num - eff_head;
  assign ram_waddr = head_slot_r + diff[WIN_AW-1:0];

  always_comb begin
    state_nxt      = state_r;
    head_num_nxt   = head_num_r;
    head_slot_nxt  = head_slot_r;
    started_nxt    = started_r;
    valid_nxt      = valid_r;
    out_strobe_nxt = 1'b0;
    out_item_nxt   = out_item_r;
    ram_we         = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt                = S_IDLE;
        out_strobe_nxt           = 1'b1;
        out_item_nxt.status      = ST_OK;
        out_item_nxt.data_valid  = 1'b0;
        out_item_nxt.payload_out = '0;
        out_item_nxt.head_out    = head_num_r;
        case (item_r.action)
          ACT_PUSH: begin
            started_nxt           = 1'b1;
            head_num_nxt          = eff_head;
            out_item_nxt.head_out = eff_head;
            if (item_r.seq_num < eff_head) begin
              out_item_nxt.status = ST_STALE;
            end else if (diff[NUM_W-1:WIN_AW] != '0) begin
              out_item_nxt.status = ST_BEYOND;
            end else begin
              ram_we               = 1'b1;
              valid_nxt[ram_waddr] = 1'b1;
            end
          end
          ACT_POP, ACT_PEEK: begin
            if (!started_r || !valid_r[head_slot_r]) begin
              out_item_nxt.status = ST_NOT_READY;
            end else begin
              out_item_nxt.data_valid  = 1'b1;
              out_item_nxt.payload_out = ram_rdata;
              if (item_r.action == ACT_POP) begin
                valid_nxt[head_slot_r] = 1'b0;
                head_slot_nxt          = head_slot_r + 1'b1;
                head_num_nxt           = head_num_r + 1'b1;
              end
            end
          end
          default: begin
          end
        endcase
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      start_num_r  <= '0;
      head_num_r   <= '0;
      head_slot_r  <= '0;
      started_r    <= 1'b0;
      valid_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      head_num_r   <= head_num_nxt;
      head_slot_r  <= head_slot_nxt;
      started_r    <= started_nxt;
      valid_r      <= valid_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (cfg_we) begin
        start_num_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
    out_item_r <= out_item_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

`ifndef SYNTH
  a_strobe_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(accept, 2))
    else $error("result strobe without an accepted transaction");

  a_valid_means_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.data_valid) |-> (out_item.status == ST_OK))
    else $error("head data returned with a failing status");

  a_pop_advances_head: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC && item_r.action == ACT_POP && started_r && valid_r[head_slot_r])
      |=> (head_slot_r == $past(head_slot_r) + 1'b1) && !valid_r[$past(head_slot_r)])
    else $error("pop did not advance and free the head slot");
`endif

endmodule
`default_nettype wire
